// ===== rtl/vrfc_pkg.sv =====
// Shared types, codes and helpers for the voxel row face culler.
`default_nettype none

package vrfc_pkg;

  // Geometry defaults
  localparam int SIZE_DEFAULT        = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Field widths
  localparam int AXIS_W  = 2;
  localparam int ROW_W   = 10;
  localparam int OCC_W   = 32;
  localparam int BIT_W   = 5;
  localparam int COORD_W = 5;
  localparam int DIR_W   = 3;

  // Stream payload widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USED_W = DIR_W + 3 * COORD_W;

  // Row axis codes
  localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  // Face direction codes
  localparam logic [DIR_W-1:0] DIR_TOP     = 3'd0;
  localparam logic [DIR_W-1:0] DIR_BOTTOM  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT   = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT    = 3'd3;
  localparam logic [DIR_W-1:0] DIR_FORWARD = 3'd4;
  localparam logic [DIR_W-1:0] DIR_BACK    = 3'd5;

  // One classified row, waiting for face emission
  typedef struct packed {
    logic [OCC_W-1:0]   pos_mask;
    logic [OCC_W-1:0]   neg_mask;
    logic [AXIS_W-1:0]  axis;
    logic [COORD_W-1:0] coord_low;
    logic [COORD_W-1:0] coord_high;
  } face_desc_t;

  // Index of the lowest set bit (zero when the word is empty)
  function automatic logic [BIT_W-1:0] lowest_bit(input logic [OCC_W-1:0] word);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = OCC_W - 1; i >= 0; i--) begin
      if (word[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vrfc_front.sv =====
// Front end: accepts rows, drops idle ones, builds face masks and coordinates.
`default_nettype none

module vrfc_front import vrfc_pkg::*; #(
  parameter int SIZE = SIZE_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [AXIS_W-1:0]    s_tuser,
  output logic                 desc_valid,
  input  logic                 desc_ready,
  output face_desc_t           desc
);

  // Reciprocal divide by SIZE, exact for any 10-bit row index
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP       = (2 ** RECIP_SHIFT + SIZE - 1) / SIZE;
  localparam int PROD_W      = ROW_W + RECIP_SHIFT + 1;
  localparam int REM_W       = 16;
  localparam logic [OCC_W-1:0] ROW_MASK =
    (SIZE >= OCC_W) ? {OCC_W{1'b1}} : OCC_W'((64'd1 << SIZE) - 64'd1);

  logic              in_xfer;
  logic [ROW_W-1:0]  in_row;
  logic [OCC_W-1:0]  in_occ;
  logic              in_keep;
  logic [PROD_W-1:0] quot_prod;

  logic              s1_valid;
  logic [AXIS_W-1:0] s1_axis;
  logic [ROW_W-1:0]  s1_row;
  logic [OCC_W-1:0]  s1_occ;
  logic [ROW_W-1:0]  s1_quot;

  logic [REM_W-1:0]  back_prod;
  logic [REM_W-1:0]  rem_raw;
  logic [REM_W-1:0]  rem_fix;
  logic [ROW_W-1:0]  quot_fix;

  assign in_xfer   = s_tvalid && s_tready;
  assign in_row    = s_tdata[ROW_W-1:0];
  assign in_occ    = s_tdata[ROW_W+OCC_W-1:ROW_W] & ROW_MASK;
  assign in_keep   = (s_tuser != AXIS_NONE) && (in_occ != '0);
  assign quot_prod = PROD_W'(in_row) * PROD_W'(RECIP);

  assign s_tready   = !s1_valid || desc_ready;
  assign desc_valid = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= in_xfer && in_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_axis <= s_tuser;
      s1_row  <= in_row;
      s1_occ  <= in_occ;
      s1_quot <= quot_prod[RECIP_SHIFT +: ROW_W];
    end
  end

  // remainder with a one-step correction
  always_comb begin
    back_prod = REM_W'(s1_quot) * REM_W'(SIZE);
    rem_raw   = REM_W'(s1_row) - back_prod;
    rem_fix   = rem_raw;
    quot_fix  = s1_quot;
    if (rem_raw >= REM_W'(SIZE)) begin
      rem_fix  = rem_raw - REM_W'(SIZE);
      quot_fix = s1_quot + ROW_W'(1);
    end
  end

  always_comb begin
    desc.pos_mask   = s1_occ & ~(s1_occ >> 1);
    desc.neg_mask   = s1_occ & ~(s1_occ << 1);
    desc.axis       = s1_axis;
    desc.coord_low  = rem_fix[COORD_W-1:0];
    desc.coord_high = quot_fix[COORD_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/vrfc_queue.sv =====
// Small register queue between the front end and the face emitter.
`default_nettype none

module vrfc_queue import vrfc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  face_desc_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output face_desc_t out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  face_desc_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = count != CNT_W'(DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vrfc_back.sv =====
// Back end: walks the face masks and emits one face record per cycle while the output is not stalled.
`default_nettype none

module vrfc_back import vrfc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  desc_valid,
  output logic                  desc_ready,
  input  face_desc_t            desc,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  logic               cur_valid;
  logic [OCC_W-1:0]   cur_pos;
  logic [OCC_W-1:0]   cur_neg;
  logic [AXIS_W-1:0]  cur_axis;
  logic [COORD_W-1:0] cur_low;
  logic [COORD_W-1:0] cur_high;

  logic               use_pos;
  logic [OCC_W-1:0]   sel;
  logic [OCC_W-1:0]   sel_rest;
  logic [BIT_W-1:0]   bit_pos;
  logic               is_last;
  logic               emit;
  logic [DIR_W-1:0]   dir;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [COORD_W-1:0] pos_z;

  // positive faces first, then negative
  assign use_pos  = cur_pos != '0;
  assign sel      = use_pos ? cur_pos : cur_neg;
  assign sel_rest = sel & (sel - OCC_W'(1));
  assign bit_pos  = lowest_bit(sel);
  assign is_last  = (sel_rest == '0) && (!use_pos || (cur_neg == '0));

  assign emit       = cur_valid && (!m_tvalid || m_tready);
  assign desc_ready = !cur_valid || (emit && is_last);

  always_comb begin
    unique case (cur_axis)
      AXIS_X: begin
        dir   = use_pos ? DIR_RIGHT : DIR_LEFT;
        pos_x = COORD_W'(bit_pos);
        pos_y = cur_high;
        pos_z = cur_low;
      end
      AXIS_Z: begin
        dir   = use_pos ? DIR_BACK : DIR_FORWARD;
        pos_x = cur_low;
        pos_y = cur_high;
        pos_z = COORD_W'(bit_pos);
      end
      default: begin
        dir   = use_pos ? DIR_TOP : DIR_BOTTOM;
        pos_x = cur_low;
        pos_y = COORD_W'(bit_pos);
        pos_z = cur_high;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (desc_ready) begin
        cur_valid <= desc_valid;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_ready && desc_valid) begin
      cur_pos  <= desc.pos_mask;
      cur_neg  <= desc.neg_mask;
      cur_axis <= desc.axis;
      cur_low  <= desc.coord_low;
      cur_high <= desc.coord_high;
    end else if (emit) begin
      if (use_pos) begin
        cur_pos <= sel_rest;
      end else begin
        cur_neg <= sel_rest;
      end
    end
    if (emit) begin
      m_tdata <= {(OUT_DATA_W - OUT_USED_W)'(0), pos_z, pos_y, pos_x, dir};
      m_tlast <= is_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/voxel_row_face_culler.sv =====
// Top level of the voxel row face culler.
`default_nettype none

// Takes one occupancy row of a voxel chunk per transfer and returns one face
// record per exposed voxel face: first the positive-side faces by ascending
// bit, then the negative-side faces, with tlast on the final record of the
// row. The front end takes a row per cycle while its two-entry queue has
// room; the back end sends one face per cycle while the output is not
// stalled, and a row holds 2 faces per solid run, up to 32. Rows with axis
// three or no solid voxels give no records and are dropped by the front end.
// The first face of a row passes the front-end register, the queue, the
// back-end row register and the output register. Row indexes at or above
// SIZE squared are not checked; coordinates simply wrap to 5 bits.
module voxel_row_face_culler import vrfc_pkg::*; #(
  parameter int SIZE        = SIZE_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // input rows
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // row_index[9:0], occupancy[41:10], zero pad
  input  logic [AXIS_W-1:0]     s_tuser,  // axis[1:0]
  // face records
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // direction[2:0], pos_x[7:3], pos_y[12:8],
                                          // pos_z[17:13], zero pad
  output logic                  m_tlast   // last_face
);

  face_desc_t front_desc;
  logic       front_valid;
  logic       front_ready;
  face_desc_t back_desc;
  logic       back_valid;
  logic       back_ready;

  // classify and prepare masks / coordinates
  vrfc_front #(
    .SIZE (SIZE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .desc_valid (front_valid),
    .desc_ready (front_ready),
    .desc       (front_desc)
  );

  // decouples row intake from face emission
  vrfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_desc),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_data  (back_desc)
  );

  // one face per cycle into the output register while it is not stalled
  vrfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (back_valid),
    .desc_ready (back_ready),
    .desc       (back_desc),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/vrfc_checker.sv =====
// Port-level checks for the voxel row face culler, bound to the top level.
`default_nettype none

module vrfc_checker import vrfc_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tlast
);

  // reset empties the output register and frees the input
  a_reset_clear: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output not idle or input not ready after reset");

  // stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("face record changed while stalled");

  // only the six face directions are emitted
  a_dir: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[DIR_W-1:0] <= DIR_BACK)
    else $error("bad face direction");

  // padding above the record fields stays zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
    else $error("nonzero padding in face record");

endmodule

bind voxel_row_face_culler vrfc_checker u_vrfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== verif/voxel_row_face_culler_tb.sv =====
// Testbench for voxel_row_face_culler: directed and random rows with a face predictor.
`timescale 1ns / 1ps

// Rows go in on the s_* stream and face records come out on the m_* stream.
// Every accepted row is culled by a local predictor. The predictor queues the
// expected faces in emission order: positive side by ascending bit, then
// negative side, with the last face flagged. A checker process compares each
// face transfer with the oldest queued face. Both stream sides idle at random.
// One phase runs with no idling. In another phase the receiver holds off long
// enough for the row queue to fill and stall the input.
module voxel_row_face_culler_tb;
  import vrfc_pkg::*;

  localparam int ROW_SIZE     = SIZE_DEFAULT;
  localparam int IDLE_PCT     = 21;
  localparam int DRAIN_CYCLES = 16;     // leave room for stray faces

  // One expected face record
  typedef struct packed {
    logic [DIR_W-1:0]   dir;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               is_last;
  } face_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;  // row_index[9:0], occupancy[41:10], zero pad
  logic [AXIS_W-1:0]     s_tuser = '0;  // axis[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;       // direction[2:0], pos_x[7:3], pos_y[12:8],
                                        // pos_z[17:13], zero pad
  logic                  m_tlast;

  face_t       faces_due[$];      // faces predicted but not yet seen
  int unsigned mismatches = 0;
  int unsigned src_idle_pct = IDLE_PCT;
  int unsigned snk_idle_pct = IDLE_PCT;
  int unsigned snk_hold_cycles = 0;  // set at negedge, counted down by the receiver

  voxel_row_face_culler uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor: culls one row into the faces it must produce
  function automatic void cull_row(input logic [AXIS_W-1:0] ax,
                                   input logic [ROW_W-1:0]  row,
                                   input logic [OCC_W-1:0]  occ);
    logic [OCC_W-1:0]   side_mask[2];
    logic [DIR_W-1:0]   side_dir[2];
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic [COORD_W-1:0] b5;
    face_t              f;
    int                 first;
    if (ax == AXIS_NONE) return;   // axis three: ignored entirely
    side_mask[0] = occ & ~(occ >> 1);   // solid, next voxel clear
    side_mask[1] = occ & ~(occ << 1);   // solid, previous voxel clear
    lo = COORD_W'(row % ROW_SIZE);
    hi = COORD_W'(row / ROW_SIZE);
    case (ax)
      AXIS_X: begin
        side_dir[0] = DIR_RIGHT;
        side_dir[1] = DIR_LEFT;
      end
      AXIS_Z: begin
        side_dir[0] = DIR_BACK;
        side_dir[1] = DIR_FORWARD;
      end
      default: begin
        side_dir[0] = DIR_TOP;
        side_dir[1] = DIR_BOTTOM;
      end
    endcase
    first = faces_due.size();
    for (int side = 0; side < 2; side++) begin
      for (int b = 0; b < OCC_W; b++) begin
        if (side_mask[side][b]) begin
          b5 = COORD_W'(b);
          f.dir     = side_dir[side];
          f.is_last = 1'b0;
          // the bit position fills the scanned axis
          case (ax)
            AXIS_X: begin
              f.x = b5; f.y = hi; f.z = lo;
            end
            AXIS_Z: begin
              f.x = lo; f.y = hi; f.z = b5;
            end
            default: begin
              f.x = lo; f.y = b5; f.z = hi;
            end
          endcase
          faces_due = {faces_due, f};
        end
      end
    end
    if (faces_due.size() > first) begin
      f = faces_due[faces_due.size() - 1];
      f.is_last = 1'b1;
      faces_due[faces_due.size() - 1] = f;
    end
  endfunction

  // Offer one row; predict its faces at the transfer
  task automatic send_row(input logic [AXIS_W-1:0] ax, input logic [ROW_W-1:0] row,
                          input logic [OCC_W-1:0] occ);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ax;
    s_tdata  <= {{(IN_DATA_W - OCC_W - ROW_W){1'b0}}, occ, row};
    do @(posedge clk); while (!s_tready);
    cull_row(ax, row, occ);
  endtask

  // Sender pause: drop valid and wait for every predicted face
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (faces_due.size() != 0) @(posedge clk);
  endtask

  // Random occupancy word, biased toward interesting shapes
  function automatic logic [OCC_W-1:0] rand_occupancy();
    logic [OCC_W-1:0] w;
    int               pos;
    case ($urandom_range(7))
      0: w = $urandom() & $urandom() & $urandom();      // sparse
      1: w = $urandom() | $urandom();                   // dense
      2: begin                                          // a few solid runs
        w = '0;
        repeat ($urandom_range(4, 1)) begin
          pos = $urandom_range(OCC_W - 1);
          w |= ((OCC_W'(1) << $urandom_range(12, 1)) - 1) << pos;
        end
      end
      3: w = $urandom_range(1) ? 32'h5555_5555 : 32'hAAAA_AAAA;  // most faces
      4: w = OCC_W'(1) << $urandom_range(OCC_W - 1);    // single voxel
      5: w = $urandom_range(3) == 0 ? '0 : '1;          // empty or full row
      default: w = $urandom();
    endcase
    return w;
  endfunction

  // Random rows; ignored axis-three rows are mixed in but not counted
  task automatic run_random_rows(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 8) begin
        send_row(AXIS_NONE, ROW_W'($urandom()), $urandom());
      end else begin
        send_row(AXIS_W'($urandom_range(2)), ROW_W'($urandom_range(1023)),
                 rand_occupancy());
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    send_row(AXIS_X, 10'd0,    32'h0000_0001);   // single voxel at bit 0
    send_row(AXIS_Z, 10'd1023, 32'h8000_0000);   // single voxel at bit 31, max row
    send_row(AXIS_Y, 10'd1023, 32'hFFFF_FFFF);   // full row: two end faces
    send_row(AXIS_X, 10'd31,   32'h0000_0000);   // empty row: no faces
    send_row(AXIS_Z, 10'd32,   32'h5555_5555);   // alternating: 32 faces
    send_row(AXIS_Y, 10'd992,  32'hAAAA_AAAA);
    send_row(AXIS_NONE, 10'h3FF, 32'hFFFF_FFFF); // axis three: ignored
    send_row(AXIS_NONE, 10'd0, 32'h0000_0001);
    send_row(AXIS_X, 10'h2AA,  32'h8000_0001);   // both row ends solid
    send_row(AXIS_Z, 10'h155,  32'h7FFF_FFFE);
    send_row(AXIS_Y, 10'd33,   32'h0F0F_00F0);
    send_row(AXIS_X, 10'd1000, 32'hFFFF_0000);
    send_row(AXIS_Z, 10'd0,    32'h0000_FFFF);
    send_row(AXIS_Y, 10'd0,    32'h0000_0000);
    send_row(AXIS_X, 10'd1023, 32'h0000_0003);
    send_row(AXIS_Y, 10'd31,   32'hC000_0000);
  endtask

  // Long stretch with no idling on either side
  task automatic test_no_idle();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random_rows(25);
    src_idle_pct = IDLE_PCT;
    snk_idle_pct = IDLE_PCT;
  endtask

  // Receiver holds off while dense rows keep coming, so the input stalls
  task automatic test_back_pressure();
    s_tvalid <= 1'b0;
    @(negedge clk);
    snk_hold_cycles = 300;
    @(posedge clk);
    repeat (12) send_row(AXIS_W'($urandom_range(2)), ROW_W'($urandom()),
                         $urandom() | $urandom());
  endtask

  // Receiver: random stalls, plus a requested hold counted here
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (snk_hold_cycles != 0) begin
      m_tready <= 1'b0;
      snk_hold_cycles <= snk_hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Checker: each face transfer against the oldest predicted face
  always @(posedge clk) begin
    face_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (faces_due.size() == 0) begin
        $error("unexpected face transfer: tdata=%h tlast=%b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = faces_due.pop_front();
        if (m_tdata[2:0] !== want.dir) begin
          $error("direction: expected %0d, got %0d", want.dir, m_tdata[2:0]);
          mismatches++;
        end
        if (m_tdata[7:3] !== want.x) begin
          $error("pos_x: expected %0d, got %0d", want.x, m_tdata[7:3]);
          mismatches++;
        end
        if (m_tdata[12:8] !== want.y) begin
          $error("pos_y: expected %0d, got %0d", want.y, m_tdata[12:8]);
          mismatches++;
        end
        if (m_tdata[17:13] !== want.z) begin
          $error("pos_z: expected %0d, got %0d", want.z, m_tdata[17:13]);
          mismatches++;
        end
        if (m_tlast !== want.is_last) begin
          $error("last_face: expected %0d, got %0d", want.is_last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    run_random_rows(30);
    wait_drained();          // sender pause until all faces are back
    test_no_idle();
    test_back_pressure();
    wait_drained();
    run_random_rows(25);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("voxel_row_face_culler verification clean");
    end else begin
      $display("voxel_row_face_culler verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("voxel_row_face_culler verification failed");
    $finish;
  end

endmodule
